// ----- rtl/dltq_pkg.sv -----
// dltq_pkg: types and codes shared by the delta list timer queue.
// No dependencies.
`timescale 1ns / 1ps

package dltq_pkg;

  localparam int MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic {
    KIND_EXPIRED = 1'b0,
    KIND_QUERY   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  timer_id;
    logic [31:0] interval;
    logic        periodic;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] timer_id_res;
    logic       started;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINK_RD,
    ST_LINK_CMP,
    ST_LINK_ADJ,
    ST_LINK_FIX,
    ST_LINK_SPL,
    ST_UNL_RD,
    ST_UNL_CMP,
    ST_UNL_ADD,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_ADJ
  } state_e;

endpackage

// ----- rtl/delta_list_timer_queue.sv -----
// delta_list_timer_queue: top level, sequencer and list storage.
// Depends on dltq_pkg.
`timescale 1ns / 1ps

// Usage: drive in_i and raise start_i; the item is taken at an edge where
// busy_o is low, and busy_o is high from the next cycle until it is done.
// Results appear on res_o for one cycle each, marked by res_valid_o; the
// receiver cannot stall, so nothing backs up. res_o.last marks the final
// result of an item.
// A query answers in the cycle after it is taken and never sets busy_o.
// Start walks the list through the shared add/sub unit, reading each entry
// in ST_LINK_RD and comparing in ST_LINK_CMP, then closes with ST_LINK_ADJ,
// ST_LINK_FIX and ST_LINK_SPL as needed. Stop reads and compares each entry
// up to its slot, then ST_UNL_ADD adds the victim delta to any follower. A
// tick checks each expiring timer, runs a start walk for each periodic one,
// and closes with ST_TICK_RD, ST_TICK_CHK and ST_TICK_ADJ (ST_TICK_RD only
// if the list empties). Expiry results leave one expiry late so that last
// can be set on the final one. The list stores read at most one entry per cycle.
// Reset empties the list and clears all linked flags at once; no
// clearing pass is needed.
module delta_list_timer_queue #(
  parameter int TIMER_SLOTS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  dltq_pkg::in_item_t  in_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output dltq_pkg::out_item_t res_o
);

  localparam int IW = $clog2(TIMER_SLOTS + 1);
  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(dltq_pkg::MAX_RESULTS + 1);
  localparam logic [IW-1:0] NIL = IW'(TIMER_SLOTS);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [COUNT_BITS-1:0] delta_mem [TIMER_SLOTS];
  logic [IW-1:0]         next_mem  [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] ival_mem  [TIMER_SLOTS];
  logic                  per_mem   [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] linked_q, linked_d;

  dltq_pkg::state_e state_q, state_d;
  logic [IW-1:0]          head_q, head_d;
  logic [IW-1:0]          walk_q, walk_d, before_q, before_d;
  logic [SW-1:0]          slot_q, slot_d;
  logic [COUNT_BITS-1:0]  rem_q, rem_d;
  logic                   tick_q, tick_d;   // link walk runs inside a tick
  logic                   el_q, el_d;       // elapsed left in this tick
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]  rd_delta_q;
  logic [IW-1:0]          rd_next_q;
  logic                   rd_per_q;
  logic [COUNT_BITS-1:0]  rd_ival_q;
  logic                   res_valid_q, res_valid_d;
  dltq_pkg::out_item_t    res_q, res_d;
  dltq_pkg::out_item_t    pend_q, pend_d;
  logic                   pend_v_q, pend_v_d;

  // memory port control
  logic                  rd_en;
  logic [SW-1:0]         rd_addr;
  logic                  wd_en, wn_en, wi_en;
  logic [SW-1:0]         wd_addr, wn_addr;
  logic [COUNT_BITS-1:0] wd_data;
  logic [IW-1:0]         wn_data;

  // shared add/sub unit; for subtract, the top bit is set when a >= b
  logic [COUNT_BITS-1:0] alu_a, alu_b;
  logic                  alu_sub;
  logic [COUNT_BITS:0]   alu_y;
  logic                  alu_ge;
  logic                  due;

  logic [COUNT_BITS-1:0] iv_sat;
  logic [SW-1:0] id_slot;
  logic id_ok;

  always_comb begin
    if (COUNT_BITS < 32 && (in_i.interval >> COUNT_BITS) != 32'd0) iv_sat = CMAX;
    else iv_sat = COUNT_BITS'(in_i.interval);
    if (iv_sat == '0) iv_sat = COUNT_BITS'(1);
    id_ok   = 32'(in_i.timer_id) < 32'(TIMER_SLOTS);
    id_slot = SW'(in_i.timer_id);
  end

  always_comb begin
    alu_a = rem_q; alu_b = rd_delta_q; alu_sub = 1'b1;
    case (state_q)
      dltq_pkg::ST_LINK_ADJ: begin
        alu_a = rd_delta_q; alu_b = rem_q;
      end
      dltq_pkg::ST_UNL_ADD: begin
        alu_a = rd_delta_q; alu_b = rem_q; alu_sub = 1'b0;
      end
      dltq_pkg::ST_TICK_CHK: alu_a = {{(COUNT_BITS-1){1'b0}}, el_q};
      dltq_pkg::ST_TICK_ADJ: begin
        alu_a = rd_delta_q; alu_b = {{(COUNT_BITS-1){1'b0}}, el_q};
      end
      default: ;
    endcase
  end

  assign alu_y = {1'b0, alu_a} + {1'b0, alu_b ^ {COUNT_BITS{alu_sub}}}
               + {{COUNT_BITS{1'b0}}, alu_sub};
  assign alu_ge = alu_y[COUNT_BITS];
  assign due = (cnt_q < CW'(dltq_pkg::MAX_RESULTS)) && alu_ge;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_delta_q <= delta_mem[rd_addr];
      rd_next_q  <= next_mem[rd_addr];
      rd_per_q   <= per_mem[rd_addr];
      rd_ival_q  <= ival_mem[rd_addr];
    end
    if (wd_en) delta_mem[wd_addr] <= wd_data;
    if (wn_en) next_mem[wn_addr] <= wn_data;
    if (wi_en) begin
      ival_mem[id_slot] <= iv_sat;
      per_mem[id_slot]  <= in_i.periodic;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dltq_pkg::ST_IDLE: begin
        if (start_i) begin
          case (dltq_pkg::action_e'(in_i.action))
            dltq_pkg::ACT_START:
              if (id_ok && !linked_q[id_slot]) state_d = dltq_pkg::ST_LINK_RD;
            dltq_pkg::ACT_STOP:
              if (id_ok && linked_q[id_slot]) state_d = dltq_pkg::ST_UNL_RD;
            dltq_pkg::ACT_TICK: state_d = dltq_pkg::ST_TICK_RD;
            default: ;
          endcase
        end
      end
      dltq_pkg::ST_LINK_RD:
        state_d = (walk_q == NIL) ? dltq_pkg::ST_LINK_FIX : dltq_pkg::ST_LINK_CMP;
      dltq_pkg::ST_LINK_CMP:
        state_d = alu_ge ? dltq_pkg::ST_LINK_RD : dltq_pkg::ST_LINK_ADJ;
      dltq_pkg::ST_LINK_ADJ: state_d = dltq_pkg::ST_LINK_FIX;
      dltq_pkg::ST_LINK_FIX:
        if (before_q != NIL) state_d = dltq_pkg::ST_LINK_SPL;
        else state_d = tick_q ? dltq_pkg::ST_TICK_RD : dltq_pkg::ST_IDLE;
      dltq_pkg::ST_LINK_SPL:
        state_d = tick_q ? dltq_pkg::ST_TICK_RD : dltq_pkg::ST_IDLE;
      dltq_pkg::ST_UNL_RD: state_d = dltq_pkg::ST_UNL_CMP;
      dltq_pkg::ST_UNL_CMP:
        if (walk_q == IW'(slot_q))
          state_d = (rd_next_q != NIL) ? dltq_pkg::ST_UNL_ADD : dltq_pkg::ST_IDLE;
        else state_d = dltq_pkg::ST_UNL_RD;
      dltq_pkg::ST_UNL_ADD: state_d = dltq_pkg::ST_IDLE;
      dltq_pkg::ST_TICK_RD:
        state_d = (head_q == NIL) ? dltq_pkg::ST_IDLE : dltq_pkg::ST_TICK_CHK;
      dltq_pkg::ST_TICK_CHK:
        if (due) state_d = rd_per_q ? dltq_pkg::ST_LINK_RD : dltq_pkg::ST_TICK_RD;
        else state_d = dltq_pkg::ST_TICK_ADJ;
      dltq_pkg::ST_TICK_ADJ: state_d = dltq_pkg::ST_IDLE;
      default: state_d = dltq_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d = head_q; walk_d = walk_q; before_d = before_q; slot_d = slot_q;
    rem_d = rem_q; tick_d = tick_q; el_d = el_q; cnt_d = cnt_q; linked_d = linked_q;
    res_valid_d = 1'b0; res_d = res_q; pend_d = pend_q; pend_v_d = pend_v_q;
    rd_en = 1'b0; rd_addr = SW'(walk_q);
    wd_en = 1'b0; wd_addr = SW'(walk_q); wd_data = alu_y[COUNT_BITS-1:0];
    wn_en = 1'b0; wn_addr = slot_q; wn_data = walk_q;
    wi_en = 1'b0;
    case (state_q)
      dltq_pkg::ST_IDLE: begin
        if (start_i) begin
          slot_d = id_slot; walk_d = head_q; before_d = NIL;
          tick_d = 1'b0; el_d = 1'b1; cnt_d = '0; rem_d = iv_sat;
          case (dltq_pkg::action_e'(in_i.action))
            dltq_pkg::ACT_START: wi_en = id_ok && !linked_q[id_slot];
            dltq_pkg::ACT_QUERY: begin
              res_valid_d = 1'b1;
              res_d.kind = dltq_pkg::KIND_QUERY;
              res_d.timer_id_res = in_i.timer_id;
              res_d.started = id_ok && linked_q[id_slot];
              res_d.last = 1'b1;
            end
            default: ;
          endcase
        end
      end
      dltq_pkg::ST_LINK_RD: rd_en = (walk_q != NIL);
      dltq_pkg::ST_LINK_CMP: begin
        if (alu_ge) begin
          rem_d = alu_y[COUNT_BITS-1:0];
          before_d = walk_q; walk_d = rd_next_q;
        end
      end
      dltq_pkg::ST_LINK_ADJ: wd_en = 1'b1;  // follower keeps delta - rem
      dltq_pkg::ST_LINK_FIX: begin
        wd_en = 1'b1; wd_addr = slot_q; wd_data = rem_q;
        wn_en = 1'b1; wn_addr = slot_q; wn_data = walk_q;
        if (before_q == NIL) head_d = IW'(slot_q);
        linked_d[slot_q] = 1'b1;
      end
      dltq_pkg::ST_LINK_SPL: begin
        wn_en = 1'b1; wn_addr = SW'(before_q); wn_data = IW'(slot_q);
      end
      dltq_pkg::ST_UNL_RD: rd_en = 1'b1;
      dltq_pkg::ST_UNL_CMP: begin
        if (walk_q == IW'(slot_q)) begin
          rem_d = rd_delta_q;             // victim delta
          walk_d = rd_next_q;             // follower
          linked_d[slot_q] = 1'b0;
          if (before_q != NIL) begin
            wn_en = 1'b1; wn_addr = SW'(before_q); wn_data = rd_next_q;
          end else head_d = rd_next_q;
          if (rd_next_q != NIL) begin
            rd_en = 1'b1; rd_addr = SW'(rd_next_q);
          end
        end else begin
          before_d = walk_q; walk_d = rd_next_q;
        end
      end
      dltq_pkg::ST_UNL_ADD: wd_en = 1'b1;
      dltq_pkg::ST_TICK_RD: begin
        if (head_q != NIL) begin
          rd_en = 1'b1; rd_addr = SW'(head_q);
        end else if (pend_v_q) begin
          res_valid_d = 1'b1; res_d = pend_q; res_d.last = 1'b1; pend_v_d = 1'b0;
        end
      end
      dltq_pkg::ST_TICK_CHK: begin
        if (due) begin
          slot_d = SW'(head_q);
          el_d = alu_y[0];
          head_d = rd_next_q;
          linked_d[SW'(head_q)] = 1'b0;
          cnt_d = cnt_q + CW'(1);
          if (pend_v_q) begin
            res_valid_d = 1'b1; res_d = pend_q;
          end
          pend_d.kind = dltq_pkg::KIND_EXPIRED;
          pend_d.timer_id_res = 4'(head_q);
          pend_d.started = 1'b0;
          pend_d.last = 1'b0;
          pend_v_d = 1'b1;
          if (rd_per_q) begin
            rem_d = rd_ival_q; walk_d = rd_next_q; before_d = NIL; tick_d = 1'b1;
          end
        end
      end
      dltq_pkg::ST_TICK_ADJ: begin
        wd_en = 1'b1; wd_addr = SW'(head_q);
        if (pend_v_q) begin
          res_valid_d = 1'b1; res_d = pend_q; res_d.last = 1'b1; pend_v_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dltq_pkg::ST_IDLE;
      head_q <= NIL;
      linked_q <= '0;
      walk_q <= NIL;
      before_q <= NIL;
      slot_q <= '0;
      rem_q <= '0;
      tick_q <= 1'b0;
      el_q <= 1'b0;
      cnt_q <= '0;
      res_valid_q <= 1'b0;
      res_q <= '0;
      pend_q <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      linked_q <= linked_d;
      walk_q <= walk_d;
      before_q <= before_d;
      slot_q <= slot_d;
      rem_q <= rem_d;
      tick_q <= tick_d;
      el_q <= el_d;
      cnt_q <= cnt_d;
      res_valid_q <= res_valid_d;
      res_q <= res_d;
      pend_q <= pend_d;
      pend_v_q <= pend_v_d;
    end
  end

  assign busy_o = (state_q != dltq_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

endmodule
